// ===== rtl/awu_pkg.sv =====
// Shared types, constants and arithmetic step functions for the Adam weight update block.
`timescale 1ns / 1ps
package awu_pkg;

  localparam int NUM_WEIGHTS = 512;
  localparam int DEPTH       = 2 * NUM_WEIGHTS;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_INITIAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DROP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE    = 3'd5;

  localparam logic [23:0] BETA_FIRST_RST    = 24'd15099494;
  localparam logic [23:0] BETA_SECOND_RST   = 24'd16760438;
  localparam logic [31:0] RATE_INIT_RST     = 32'd26843546;
  localparam logic [24:0] DROP_FACTOR_RST   = 25'd16777216;
  localparam logic [15:0] DROP_INTERVAL_RST = 16'd200;

  // three root bits per stage over a 48-bit radicand, three quotient bits per divider stage
  localparam int SQRT_STAGES = 8;
  localparam int DIV_STAGES  = 11;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_APPLY = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_EPOCH = 2'd3
  } func_t;

  typedef struct packed {
    logic              valid;
    func_t             func;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       load_value;
    logic [31:0]       rate;
    logic              m_neg;
  } ctl_t;

  typedef struct packed {
    logic [24:0] rem;
    logic [23:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [24:0] rem;
    logic [32:0] quo;
    logic [32:0] num;
  } div_t;

  // three steps of the digit-by-digit square root, two radicand bits each
  function automatic sqrt_t sqrt_step3(sqrt_t s, logic [5:0] bits);
    sqrt_t       r;
    logic [26:0] cur;
    logic [26:0] trial;
    r = s;
    for (int i = 0; i < 3; i++) begin
      cur   = {r.rem, bits[5-2*i -: 2]};
      trial = {1'b0, r.root, 2'b01};
      if (cur >= trial) begin
        r.rem  = 25'(cur - trial);
        r.root = {r.root[22:0], 1'b1};
      end else begin
        r.rem  = 25'(cur);
        r.root = {r.root[22:0], 1'b0};
      end
    end
    return r;
  endfunction

  // three steps of restoring division
  function automatic div_t div_step3(div_t s, logic [24:0] d);
    div_t        r;
    logic [25:0] cur;
    r = s;
    for (int i = 0; i < 3; i++) begin
      cur   = {r.rem, r.num[32]};
      r.num = {r.num[31:0], 1'b0};
      if (cur >= {1'b0, d}) begin
        r.rem = 25'(cur - {1'b0, d});
        r.quo = {r.quo[31:0], 1'b1};
      end else begin
        r.rem = cur[24:0];
        r.quo = {r.quo[31:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/awu_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module awu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/adam_weight_update.sv =====
// Adam weight update: one transaction per cycle, each answered by a result strobe.
// The pipeline runs through the moment update stage, the 8-stage square root and the 11-stage divider.
// Throughput is one transaction per cycle; busy is high only during reset and the receiver
// cannot stall. Reset restores the registers and learning rate and clears the epoch count;
// the weight and moment memories are undefined until loaded.
`timescale 1ns / 1ps
module adam_weight_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic [8:0]                       weight_index,
  input  logic                             phase,
  input  logic signed [31:0]               load_value,
  input  logic signed [47:0]               gradient_sum,
  output logic                             done,
  output logic signed [31:0]               weight_out,
  output logic [31:0]                      rate_out,
  output logic                             saturated,
  input  logic                             cfg_we,
  input  logic [awu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awu_pkg::CFG_W-1:0]        cfg_data
);
  import awu_pkg::*;

  localparam int ST_MV    = 6;
  localparam int ST_LR    = ST_MV + 1;
  localparam int ST_SQ0   = ST_LR + 1;
  localparam int ST_ROOT  = ST_SQ0 + SQRT_STAGES;
  localparam int ST_DINIT = ST_ROOT + 1;
  localparam int ST_DIV0  = ST_DINIT + 1;
  localparam int ST_STEP  = ST_DIV0 + DIV_STAGES;
  localparam int ST_W     = ST_STEP + 1;

  // configuration
  logic [23:0] beta_first;
  logic [23:0] beta_second;
  logic [24:0] rate_drop_factor;
  logic [15:0] drop_interval;
  logic [47:0] scale_abs;
  logic        scale_neg;

  logic [31:0] learning_rate;
  logic [15:0] epoch_count;

  ctl_t ctl [1:ST_W];
  ctl_t ctl_next [1:ST_W];
  ctl_t ctl_in;

  assign busy = rst;

  always_comb begin
    ctl_in            = '0;
    ctl_in.valid      = start & ~busy;
    ctl_in.func       = func_t'(func);
    ctl_in.hit        = ({23'd0, weight_index} < 32'(NUM_WEIGHTS));
    ctl_in.addr       = ADDR_W'({weight_index, phase});
    ctl_in.load_value = load_value;
  end

  // ---------------- gradient scaling ----------------
  logic [47:0] gs_abs1;
  logic        neg1;
  logic [47:0] pp_hh2, pp_hl2, pp_lh2, pp_ll2;
  logic        neg2;
  logic [47:0] hh3;
  logic [49:0] mid3;
  logic        neg3;
  logic [48:0] q3;
  logic signed [31:0] g4;
  logic [31:0] gabs4;
  logic signed [57:0] c1g5;
  logic [47:0] s5;
  logic [63:0] sq_full;
  logic [24:0] c1, c2;
  logic signed [57:0] c1g6;
  logic [48:0] cs_hi6, cs_lo6;

  assign c1      = 25'd16777216 - {1'b0, beta_first};
  assign c2      = 25'd16777216 - {1'b0, beta_second};
  assign q3      = {1'b0, hh3} + 49'(mid3[49:24]);
  assign sq_full = gabs4 * gabs4;

  always_ff @(posedge clk) begin
    gs_abs1 <= gradient_sum[47] ? 48'(-gradient_sum) : gradient_sum;
    neg1    <= gradient_sum[47] ^ scale_neg;

    pp_hh2 <= gs_abs1[47:24] * scale_abs[47:24];
    pp_hl2 <= gs_abs1[47:24] * scale_abs[23:0];
    pp_lh2 <= gs_abs1[23:0] * scale_abs[47:24];
    pp_ll2 <= gs_abs1[23:0] * scale_abs[23:0];
    neg2   <= neg1;

    hh3  <= pp_hh2;
    mid3 <= 50'(pp_hl2) + 50'(pp_lh2) + 50'(pp_ll2[47:24]) + 50'd8388608;
    neg3 <= neg2;

    // round to Q8.24 and saturate to 32 bits
    if (neg3) begin
      if (q3 >= 49'h80000000) begin
        g4    <= 32'sh80000000;
        gabs4 <= 32'h80000000;
      end else begin
        g4    <= -$signed(q3[31:0]);
        gabs4 <= q3[31:0];
      end
    end else begin
      if (q3 > 49'h7FFFFFFF) begin
        g4    <= 32'sh7FFFFFFF;
        gabs4 <= 32'h7FFFFFFF;
      end else begin
        g4    <= $signed(q3[31:0]);
        gabs4 <= q3[31:0];
      end
    end

    c1g5 <= $signed({1'b0, c1}) * g4;
    s5   <= (sq_full > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : sq_full[47:0];

    c1g6   <= c1g5;
    cs_hi6 <= c2 * s5[47:24];
    cs_lo6 <= c2 * s5[23:0];
  end

  // ---------------- moment update ----------------
  logic signed [31:0] m_rdata, m_old, m_new, m_wdata;
  logic [47:0]        v_rdata, v_old, v_new, v_wdata;
  logic signed [57:0] m_sum;
  logic [57:0]        m_mag;
  logic [57:0]        m_rnd;
  logic [49:0]        v_lo;
  logic [49:0]        v_full;
  logic               mv_we;
  logic signed [31:0] m7;
  logic [47:0]        v7;

  assign mv_we = ctl[ST_MV].valid & ctl[ST_MV].hit &
                 ((ctl[ST_MV].func == FUNC_LOAD) || (ctl[ST_MV].func == FUNC_APPLY));

  always_comb begin
    // forward the entry written by the previous transaction
    if (ctl[ST_LR].valid && ctl[ST_LR].hit && ctl[ST_LR].addr == ctl[ST_MV].addr &&
        (ctl[ST_LR].func == FUNC_LOAD || ctl[ST_LR].func == FUNC_APPLY)) begin
      m_old = m7;
      v_old = v7;
    end else begin
      m_old = m_rdata;
      v_old = v_rdata;
    end
    m_sum  = $signed({1'b0, beta_first}) * m_old + c1g6;
    m_mag  = m_sum[57] ? 58'(-m_sum) : 58'(m_sum);
    m_rnd  = (m_mag + 58'd8388608) >> 24;
    m_new  = m_sum[57] ? -$signed(m_rnd[31:0]) : $signed(m_rnd[31:0]);
    v_lo   = beta_second * v_old[23:0] + 50'(cs_lo6) + 50'd8388608;
    v_full = beta_second * v_old[47:24] + 50'(cs_hi6) + 50'(v_lo[49:24]);
    v_new  = v_full[47:0];
    if (ctl[ST_MV].func == FUNC_LOAD) begin
      m_wdata = '0;
      v_wdata = '0;
    end else begin
      m_wdata = m_new;
      v_wdata = v_new;
    end
  end

  awu_ram #(.WIDTH(32), .DEPTH(DEPTH)) m_ram (
    .clk   (clk),
    .we    (mv_we),
    .waddr (ctl[ST_MV].addr),
    .wdata (m_wdata),
    .raddr (ctl[ST_MV-1].addr),
    .rdata (m_rdata)
  );

  awu_ram #(.WIDTH(48), .DEPTH(DEPTH)) v_ram (
    .clk   (clk),
    .we    (mv_we),
    .waddr (ctl[ST_MV].addr),
    .wdata (v_wdata),
    .raddr (ctl[ST_MV-1].addr),
    .rdata (v_rdata)
  );

  always_ff @(posedge clk) begin
    m7 <= m_wdata;
    v7 <= v_wdata;
  end

  // ---------------- learning rate and shared multiplier ----------------
  logic [31:0] mul_b;
  logic [63:0] prod7;
  logic [40:0] lr_rnd;
  logic [31:0] lr_drop;
  logic        do_epoch, do_drop;
  logic [15:0] epoch_count_next;
  logic [31:0] rate7;

  always_comb begin
    do_epoch = ctl[ST_LR].valid && ctl[ST_LR].func == FUNC_EPOCH;
    do_drop  = do_epoch && epoch_count == 16'd0;
    mul_b    = (ctl[ST_LR].func == FUNC_EPOCH) ? {7'd0, rate_drop_factor} :
               (m7[31] ? 32'(-m7) : 32'(m7));
    prod7    = learning_rate * mul_b;
    lr_rnd   = 41'((prod7 + 64'd8388608) >> 24);
    lr_drop  = (lr_rnd > 41'hFFFFFFFF) ? 32'hFFFFFFFF : lr_rnd[31:0];
    rate7    = do_drop ? lr_drop : learning_rate;
    epoch_count_next = epoch_count + 16'd1;
    if (epoch_count_next >= drop_interval) begin
      epoch_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_first       <= BETA_FIRST_RST;
      beta_second      <= BETA_SECOND_RST;
      rate_drop_factor <= DROP_FACTOR_RST;
      drop_interval    <= DROP_INTERVAL_RST;
      scale_abs        <= '0;
      scale_neg        <= 1'b0;
      learning_rate    <= RATE_INIT_RST;
      epoch_count      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BETA_FIRST:    beta_first <= cfg_data[23:0];
          REG_BETA_SECOND:   beta_second <= cfg_data[23:0];
          REG_RATE_INITIAL:  learning_rate <= cfg_data[31:0];
          REG_RATE_DROP:     rate_drop_factor <= cfg_data[24:0];
          REG_DROP_INTERVAL: drop_interval <= cfg_data[15:0];
          REG_GRAD_SCALE: begin
            scale_abs <= cfg_data[47] ? 48'(-cfg_data) : cfg_data;
            scale_neg <= cfg_data[47];
          end
          default: ;
        endcase
      end else if (do_epoch) begin
        learning_rate <= rate7;
        epoch_count   <= epoch_count_next;
      end
    end
  end

  // ---------------- square root ----------------
  sqrt_t       sq_st   [0:SQRT_STAGES];
  logic [47:0] sq_v    [0:SQRT_STAGES-1];
  logic [63:0] sq_prod [0:SQRT_STAGES];

  always_ff @(posedge clk) begin
    sq_st[0]   <= '0;
    sq_v[0]    <= v7;
    sq_prod[0] <= prod7;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      sq_st[k+1]   <= sqrt_step3(sq_st[k], sq_v[k][47-6*k -: 6]);
      sq_prod[k+1] <= sq_prod[k];
    end
    for (int k = 0; k < SQRT_STAGES - 1; k++) begin
      sq_v[k+1] <= sq_v[k];
    end
  end

  // ---------------- divider ----------------
  logic [24:0] d_root;
  logic [63:0] num_sum;
  logic [51:0] nsh;
  logic [24:0] dsr;
  div_t        dv   [0:DIV_STAGES];
  logic [24:0] dd   [0:DIV_STAGES-1];
  logic        dovf [0:DIV_STAGES];

  // lr*|m| + den/2, then drop the low 12 bits of the sum to form the dividend
  assign d_root  = {1'b0, sq_st[SQRT_STAGES].root} + 25'd1;
  assign num_sum = sq_prod[SQRT_STAGES] + {28'd0, d_root, 11'd0};

  always_ff @(posedge clk) begin
    nsh <= num_sum[63:12];
    dsr <= d_root;

    dv[0].rem <= {6'd0, nsh[51:33]};
    dv[0].quo <= '0;
    dv[0].num <= nsh[32:0];
    dd[0]     <= dsr;
    dovf[0]   <= ({6'd0, nsh[51:33]} >= dsr);
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv[k+1]   <= div_step3(dv[k], dd[k]);
      dovf[k+1] <= dovf[k];
    end
    for (int k = 0; k < DIV_STAGES - 1; k++) begin
      dd[k+1] <= dd[k];
    end
  end

  // ---------------- weight update ----------------
  logic [32:0]        q_step;
  logic signed [33:0] step_w;
  logic signed [31:0] w_rdata, w_old, w_clamp, w_wdata, w_result;
  logic signed [34:0] w_diff;
  logic               w_sat, w_we;
  logic               wb_wrote;
  logic [ADDR_W-1:0]  wb_addr;
  logic signed [31:0] wb_w;

  // an overflowing quotient saturates the weight either way
  assign q_step = dovf[DIV_STAGES] ? '1 : dv[DIV_STAGES].quo;

  always_ff @(posedge clk) begin
    step_w <= ctl[ST_STEP].m_neg ? -$signed({1'b0, q_step}) : $signed({1'b0, q_step});
  end

  assign w_we = ctl[ST_W].valid & ctl[ST_W].hit &
                ((ctl[ST_W].func == FUNC_LOAD) || (ctl[ST_W].func == FUNC_APPLY));

  always_comb begin
    if (wb_wrote && wb_addr == ctl[ST_W].addr) begin
      w_old = wb_w;
    end else begin
      w_old = w_rdata;
    end
    w_diff = 35'(w_old) - 35'(step_w);
    w_sat  = 1'b0;
    if (w_diff > 35'sh07FFFFFFF) begin
      w_clamp = 32'sh7FFFFFFF;
      w_sat   = 1'b1;
    end else if (w_diff < -35'sh080000000) begin
      w_clamp = 32'sh80000000;
      w_sat   = 1'b1;
    end else begin
      w_clamp = w_diff[31:0];
    end
    w_wdata = (ctl[ST_W].func == FUNC_LOAD) ? $signed(ctl[ST_W].load_value) : w_clamp;
    case (ctl[ST_W].func)
      FUNC_LOAD:  w_result = $signed(ctl[ST_W].load_value);
      FUNC_APPLY: w_result = w_clamp;
      FUNC_READ:  w_result = w_old;
      default:    w_result = '0;
    endcase
    if (!ctl[ST_W].hit) begin
      w_result = '0;
    end
  end

  awu_ram #(.WIDTH(32), .DEPTH(DEPTH)) w_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (ctl[ST_W].addr),
    .wdata (w_wdata),
    .raddr (ctl[ST_STEP].addr),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    wb_addr    <= ctl[ST_W].addr;
    wb_w       <= w_wdata;
    weight_out <= w_result;
    rate_out   <= ctl[ST_W].rate;
    saturated  <= w_sat & ctl[ST_W].hit & (ctl[ST_W].func == FUNC_APPLY);
    if (rst) begin
      wb_wrote <= 1'b0;
      done     <= 1'b0;
    end else begin
      wb_wrote <= w_we;
      done     <= ctl[ST_W].valid;
    end
  end

  // ---------------- control pipeline ----------------
  always_comb begin
    ctl_next[1] = ctl_in;
    for (int k = 2; k <= ST_W; k++) begin
      ctl_next[k] = ctl[k-1];
    end
    ctl_next[ST_SQ0].rate  = rate7;
    ctl_next[ST_SQ0].m_neg = m7[31];
    if (rst) begin
      for (int k = 1; k <= ST_W; k++) begin
        ctl_next[k].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= ST_W; k++) begin
      ctl[k] <= ctl_next[k];
    end
  end

endmodule
